### design/bf16_weight_matvec_bias_defines.svh
// ---------------------------------------------------------------------------
// bf16 weight mat-vec assertion macros
// Shared property shapes for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BF16_WEIGHT_MATVEC_BIAS_DEFINES_SVH
`define BF16_WEIGHT_MATVEC_BIAS_DEFINES_SVH

// same-cycle implication
`define BWMV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bwmv check failed");

// next-cycle implication
`define BWMV_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bwmv check failed");

`endif

### design/bwmv_pkg.sv
// ---------------------------------------------------------------------------
// bwmv_pkg
// Types, constants and fp32 helpers shared by the mat-vec block.
// ---------------------------------------------------------------------------
package bwmv_pkg;

  localparam int DEF_MAX_ROW_LENGTH = 4096;
  localparam int DEF_MAX_ROWS       = 262144;

  localparam int CFG_W     = 19;  // widest register
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 16;  // store address, widest allowed depth
  localparam int ROW_OUT_W = 18;
  localparam int BF16_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic                  is_weight;
    logic [IDX_W-1:0]      addr;
    logic [31:0]           vval;
    logic [15:0]           weight;
    logic [31:0]           bias;
    logic                  last_col;
    logic                  last_row;
    logic [ROW_OUT_W-1:0]  row;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_status_t;

  typedef struct packed {
    logic               sign;
    logic               zero;
    logic signed [10:0] exp;
    logic [31:0]        sig;
  } norm_t;

  // value = x * 2^(e0-158); left-justify x
  function automatic norm_t fp_norm(input logic sign, input logic signed [10:0] e0,
                                    input logic [31:0] x);
    norm_t r;
    logic [5:0] lz;
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) lz = 6'(31 - i);
    end
    r.sign = sign;
    r.zero = (x == 32'd0);
    r.sig  = x << lz;
    r.exp  = e0 - $signed({5'd0, lz});
    return r;
  endfunction

  // round to nearest even and pack, subnormal and overflow included
  function automatic logic [31:0] fp_round(input norm_t n);
    logic [31:0] sh;
    logic [31:0] mask;
    logic        lost;
    logic [10:0] d;
    logic [23:0] keep;
    logic        g;
    logic        st;
    logic [30:0] base;
    logic        rup;
    logic [31:0] res;
    sh = 32'd0;
    mask = 32'd0;
    lost = 1'b0;
    d = 11'd0;
    keep = 24'd0;
    g = 1'b0;
    st = 1'b0;
    base = 31'd0;
    if (n.zero) begin
      res = {n.sign, 31'd0};
    end else if (n.exp >= 11'sd255) begin
      res = {n.sign, 8'hFF, 23'd0};
    end else begin
      if (n.exp >= 11'sd1) begin
        keep = n.sig[31:8];
        g    = n.sig[7];
        st   = |n.sig[6:0];
        base = {n.exp[7:0], keep[22:0]};
      end else begin
        d = 11'(11'sd1 - n.exp);
        if (d >= 11'd32) begin
          sh   = 32'd0;
          lost = |n.sig;
        end else begin
          mask = (32'd1 << d[4:0]) - 32'd1;
          sh   = n.sig >> d[4:0];
          lost = |(n.sig & mask);
        end
        keep = sh[31:8];
        g    = sh[7];
        st   = (|sh[6:0]) | lost;
        base = {8'd0, keep[22:0]};
      end
      rup = g & (st | keep[0]);
      res = {n.sign, base + {30'd0, rup}};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] big, lit;
    logic [7:0]  eb, el, diff;
    logic [23:0] mb, ml;
    logic [26:0] ml27, sh27, mask27;
    logic        stk;
    logic [27:0] s;
    logic [31:0] res;
    norm_t       n;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    big = a;
    lit = b;
    res = 32'd0;
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      res = CANON_NAN;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = b;
    end else begin
      if (a[30:0] < b[30:0]) begin
        big = b;
        lit = a;
      end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      el = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
      mb = {big[30:23] != 8'd0, big[22:0]};
      ml = {lit[30:23] != 8'd0, lit[22:0]};
      diff = eb - el;
      ml27 = {ml, 3'b000};
      if (diff >= 8'd27) begin
        sh27 = 27'd0;
        stk  = |ml27;
      end else begin
        mask27 = (27'd1 << diff[4:0]) - 27'd1;
        sh27   = ml27 >> diff[4:0];
        stk    = |(ml27 & mask27);
      end
      sh27 = {sh27[26:1], sh27[0] | stk};
      if (big[31] == lit[31]) s = {1'b0, mb, 3'b000} + {1'b0, sh27};
      else s = {1'b0, mb, 3'b000} - {1'b0, sh27};
      if (s == 28'd0) begin
        res = {big[31] & lit[31], 31'd0};
      end else begin
        n = fp_norm(big[31], $signed({3'd0, eb}) + 11'sd1, {s, 4'b0000});
        res = fp_round(n);
      end
    end
    return res;
  endfunction

endpackage

### design/bwmv_queue.sv
// ---------------------------------------------------------------------------
// bwmv_queue
// Short FIFO of classified items between front and back.
// ---------------------------------------------------------------------------
module bwmv_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bwmv_pkg::q_entry_t  push_data,
  input  logic                pop,
  output bwmv_pkg::q_entry_t  pop_data,
  output bwmv_pkg::q_status_t status
);
  import bwmv_pkg::*;

  q_entry_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  assign pop_data     = entries[rd_ptr];
  assign status.count = count;
  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
endmodule

### design/bwmv_front.sv
// ---------------------------------------------------------------------------
// bwmv_front
// Config registers, item intake, column/row tracking and queue push.
// ---------------------------------------------------------------------------
module bwmv_front #(
  parameter int MAX_ROW_LENGTH = bwmv_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MAX_ROWS       = bwmv_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bwmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bwmv_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [11:0]                    vector_index,
  input  logic [31:0]                    vector_value,
  input  logic [15:0]                    weight,
  input  logic [31:0]                    bias_value,
  input  logic                           q_full,
  output logic                           push,
  output bwmv_pkg::q_entry_t             push_data
);
  import bwmv_pkg::*;

  localparam int AW = $clog2(MAX_ROW_LENGTH);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [12:0]   row_length;
  logic [18:0]   row_count;
  logic          bias_enable;
  logic [AW-1:0] col;
  logic [RW-1:0] row;

  logic [31:0] len32, cnt32, eff_len, eff_cnt, col_inc, row_inc, idx32, row32;
  logic        accept, idx_ok, last_col, last_row;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len32 = {19'd0, row_length};
    cnt32 = {13'd0, row_count};
    if (len32 == 32'd0) eff_len = 32'd1;
    else if (len32 > 32'(MAX_ROW_LENGTH)) eff_len = 32'(MAX_ROW_LENGTH);
    else eff_len = len32;
    if (cnt32 == 32'd0) eff_cnt = 32'd1;
    else if (cnt32 > 32'(MAX_ROWS)) eff_cnt = 32'(MAX_ROWS);
    else eff_cnt = cnt32;
    col_inc  = 32'(col) + 32'd1;
    row_inc  = 32'(row) + 32'd1;
    last_col = (col_inc >= eff_len);
    last_row = (row_inc >= eff_cnt);
    idx32    = {20'd0, vector_index};
    idx_ok   = (idx32 < 32'(MAX_ROW_LENGTH));
    row32    = 32'(row);
  end

  // out-of-range store writes are dropped here
  assign push = accept && (mode || idx_ok);

  always_comb begin
    push_data.is_weight = mode;
    push_data.addr      = mode ? IDX_W'(col) : IDX_W'(vector_index);
    push_data.vval      = vector_value;
    push_data.weight    = weight;
    push_data.bias      = bias_enable ? bias_value : 32'd0;
    push_data.last_col  = last_col;
    push_data.last_row  = last_row;
    push_data.row       = row32[ROW_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length  <= 13'd4096;
      row_count   <= 19'd1;
      bias_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_LENGTH:  row_length  <= cfg_data[12:0];
        REG_ROW_COUNT:   row_count   <= cfg_data;
        REG_BIAS_ENABLE: bias_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept && mode) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col <= col_inc[AW-1:0];
      end
    end
  end
endmodule

### design/bwmv_back.sv
// ---------------------------------------------------------------------------
// bwmv_back
// Vector store, fp32 multiply pipe, running accumulator and bias add.
// ---------------------------------------------------------------------------
module bwmv_back #(
  parameter int MAX_ROW_LENGTH = bwmv_pkg::DEF_MAX_ROW_LENGTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  bwmv_pkg::q_entry_t             q_data,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bwmv_pkg::ROW_OUT_W-1:0] row_index,
  output logic [31:0]                    row_result,
  output logic                           last_row
);
  import bwmv_pkg::*;

  localparam int AW = $clog2(MAX_ROW_LENGTH);

  typedef struct packed {
    logic                 last_col;
    logic                 last_row;
    logic [ROW_OUT_W-1:0] row;
    logic [31:0]          bias;
  } meta_t;

  logic [31:0] mem [MAX_ROW_LENGTH];
  logic        adv;
  logic        v1, v2, v3, v4, v5;
  meta_t       m1, m2, m3, m4, m5;
  logic [15:0] w1;
  logic [31:0] x1;
  logic [AW-1:0] addr;

  // multiply stage
  logic               s2_sign, s2_nan, s2_inf;
  logic signed [10:0] s2_e0;
  logic [31:0]        s2_p;
  norm_t              s3_n;
  logic               s3_nan, s3_inf;
  logic [31:0]        s4_prod;
  logic [31:0]        acc;
  logic [31:0]        s5_sum;

  logic [7:0]  ea, eb, exa, exb;
  logic [6:0]  fa;
  logic [22:0] fb;
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
  logic        mul_nan, mul_inf;
  logic [7:0]  sig_a;
  logic [23:0] sig_b;
  logic [31:0] sum_next;

  assign adv  = !out_valid || out_ready;
  assign pop  = adv && q_valid;
  assign addr = q_data.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      if (!q_data.is_weight) mem[addr] <= q_data.vval;
      x1 <= mem[addr];
    end
  end

  always_comb begin
    ea = w1[14:7];
    fa = w1[6:0];
    eb = x1[30:23];
    fb = x1[22:0];
    a_nan  = (ea == 8'hFF) && (fa != 7'd0);
    a_inf  = (ea == 8'hFF) && (fa == 7'd0);
    a_zero = (ea == 8'd0) && (fa == 7'd0);
    b_nan  = (eb == 8'hFF) && (fb != 23'd0);
    b_inf  = (eb == 8'hFF) && (fb == 23'd0);
    b_zero = (eb == 8'd0) && (fb == 23'd0);
    mul_nan = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    mul_inf = (a_inf || b_inf) && !mul_nan;
    sig_a = {ea != 8'd0, fa};
    sig_b = {eb != 8'd0, fb};
    exa = (ea == 8'd0) ? 8'd1 : ea;
    exb = (eb == 8'd0) ? 8'd1 : eb;
    sum_next = fp_add(acc, s4_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      acc <= 32'd0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= pop && q_data.is_weight;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4 && m4.last_col;
      if (v4) acc <= m4.last_col ? 32'd0 : sum_next;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= q_data.weight;
      m1 <= '{last_col: q_data.last_col, last_row: q_data.last_row,
              row: q_data.row, bias: q_data.bias};
      // widened weight has an 8-bit significand
      s2_sign <= w1[15] ^ x1[31];
      s2_nan  <= mul_nan;
      s2_inf  <= mul_inf;
      s2_p    <= 32'(sig_a) * 32'(sig_b);
      s2_e0   <= $signed({3'd0, exa}) + $signed({3'd0, exb}) - 11'sd126;
      m2      <= m1;
      s3_n    <= fp_norm(s2_sign, s2_e0, s2_p);
      s3_nan  <= s2_nan;
      s3_inf  <= s2_inf;
      m3      <= m2;
      if (s3_nan) s4_prod <= CANON_NAN;
      else if (s3_inf) s4_prod <= {s3_n.sign, 8'hFF, 23'd0};
      else s4_prod <= fp_round(s3_n);
      m4      <= m3;
      s5_sum  <= sum_next;
      m5      <= m4;
      row_result <= fp_add(s5_sum, m5.bias);
      row_index  <= m5.row;
      last_row   <= m5.last_row;
    end
  end
endmodule

### design/bf16_weight_matvec_bias.sv
// A weight item goes via the queue and registers x1, s2, s3, s4, s5 into row_result.
// Throughput: one item per cycle, vector loads and weights alike, if out_ready allows.
// The fp32 accumulate loop in the back end, fp_add into acc, sets the per-item rate.
// Reset (rst, synchronous): registers to defaults, counters, queue and sum cleared.
// The vector store is not cleared; entries are defined once written.
// ---------------------------------------------------------------------------
// bf16_weight_matvec_bias
// y = W*x + bias with bf16 weights, fp32 vector store and fp32 accumulation.
// ---------------------------------------------------------------------------
`include "bf16_weight_matvec_bias_defines.svh"

module bf16_weight_matvec_bias #(
  parameter int MAX_ROW_LENGTH = bwmv_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MAX_ROWS       = bwmv_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bwmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bwmv_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [11:0]                    vector_index,
  input  logic [31:0]                    vector_value,
  input  logic [15:0]                    weight,
  input  logic [31:0]                    bias_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bwmv_pkg::ROW_OUT_W-1:0] row_index,
  output logic [31:0]                    row_result,
  output logic                           last_row
);
  import bwmv_pkg::*;

  logic      q_push, q_pop;
  q_entry_t  q_in, q_out;
  q_status_t q_stat;

  bwmv_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .vector_index(vector_index), .vector_value(vector_value),
    .weight(weight), .bias_value(bias_value),
    .q_full(q_stat.full), .push(q_push), .push_data(q_in)
  );

  bwmv_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in),
    .pop(q_pop), .pop_data(q_out),
    .status(q_stat)
  );

  bwmv_back #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(!q_stat.empty), .q_data(q_out), .pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_index(row_index), .row_result(row_result), .last_row(last_row)
  );

  `BWMV_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `BWMV_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty)
  `BWMV_ASSERT_NXT(a_q_count, !rst,
    q_stat.count == $past(q_stat.count) + QCNT_W'($past(q_push)) - QCNT_W'($past(q_pop)))
endmodule
